/* hw/rtl/rkp_pkg.sv */
// Shared types, constants and the base coding function for the rolling k-mer packer.
// Used by rkp_front, rkp_queue, rkp_back and rolling_kmer_packer; depends on nothing.
package rkp_pkg;

    localparam int MAX_BASES      = 128;
    localparam int NUM_WORDS      = 4;
    localparam int BASES_PER_WORD = 32;
    localparam int WORD_W         = 2 * BASES_PER_WORD;
    localparam int WINDOW_W       = NUM_WORDS * WORD_W;
    localparam int KLEN_W         = 8;
    localparam int SEEN_W         = 8;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int REG_IDX_W      = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_KMER_LENGTH   = 1'd0;
    localparam logic [KLEN_W-1:0]    KMER_LENGTH_RESET = 8'd31;

    localparam logic [7:0] CHAR_C_UPPER = 8'h43;
    localparam logic [7:0] CHAR_C_LOWER = 8'h63;
    localparam logic [7:0] CHAR_G_UPPER = 8'h47;
    localparam logic [7:0] CHAR_G_LOWER = 8'h67;
    localparam logic [7:0] CHAR_T_UPPER = 8'h54;
    localparam logic [7:0] CHAR_T_LOWER = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic [7:0] base_char;
        logic       seq_start;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] kmer_word0;
        logic [WORD_W-1:0] kmer_word1;
        logic [WORD_W-1:0] kmer_word2;
        logic [WORD_W-1:0] kmer_word3;
    } t_out_item;

    typedef struct packed {
        logic [WINDOW_W-1:0] window;
        logic [KLEN_W-1:0]   kmer_len;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    function automatic logic [1:0] base_code(input logic [7:0] c);
        logic [1:0] code;
        case (c) inside
            CHAR_C_UPPER, CHAR_C_LOWER: code = CODE_C;
            CHAR_G_UPPER, CHAR_G_LOWER: code = CODE_G;
            CHAR_T_UPPER, CHAR_T_LOWER: code = CODE_T;
            default:                    code = CODE_A;
        endcase
        return code;
    endfunction

endpackage

/* hw/rtl/rkp_queue.sv */
// Two-entry queue of packed-window jobs between the front and back parts.
// Depends on rkp_pkg for the job and push types.
module rkp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rkp_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rkp_pkg::t_job  o_job
);

    rkp_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_pop;

    assign do_pop  = i_pop && (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push.push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full)
        else $error("Job pushed into a full queue.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("Queue count out of range.");

    a_pointers_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("Queue pointers disagree with count.");

endmodule

/* hw/rtl/rkp_front.sv */
// Front part: accepts bases, codes them, shifts the window and decides whether a k-mer is due.
// Depends on rkp_pkg; pushes jobs into rkp_queue.
module rkp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  rkp_pkg::t_in_item          i_item,
    input  logic                       i_queue_full,
    input  logic [rkp_pkg::KLEN_W-1:0] i_kmer_length,
    output logic                       o_stall,
    output rkp_pkg::t_push             o_push
);

    logic [rkp_pkg::WINDOW_W-1:0] r_window;
    logic [rkp_pkg::WINDOW_W-1:0] n_window;
    logic [rkp_pkg::SEEN_W-1:0]   r_seen;
    logic [rkp_pkg::SEEN_W-1:0]   n_seen;
    logic [rkp_pkg::WINDOW_W-1:0] base_window;
    logic [rkp_pkg::SEEN_W-1:0]   base_seen;
    logic [rkp_pkg::KLEN_W-1:0]   k_eff;
    logic                         accept;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    always_comb begin
        if (i_kmer_length == '0) begin
            k_eff = rkp_pkg::KLEN_W'(1);
        end else if (i_kmer_length > rkp_pkg::KLEN_W'(rkp_pkg::MAX_BASES)) begin
            k_eff = rkp_pkg::KLEN_W'(rkp_pkg::MAX_BASES);
        end else begin
            k_eff = i_kmer_length;
        end
    end

    always_comb begin
        base_window = i_item.seq_start ? '0 : r_window;
        base_seen   = i_item.seq_start ? '0 : r_seen;
        n_window    = {base_window[rkp_pkg::WINDOW_W-3:0],
                       rkp_pkg::base_code(i_item.base_char)};
        n_seen      = (base_seen == '1) ? base_seen : base_seen + rkp_pkg::SEEN_W'(1);
    end

    always_comb begin
        o_push.push         = accept && (n_seen >= k_eff);
        o_push.job.window   = n_window;
        o_push.job.kmer_len = k_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen   <= '0;
        end else if (accept) begin
            r_window <= n_window;
            r_seen   <= n_seen;
        end
    end

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.seq_start) |=> (r_seen == rkp_pkg::SEEN_W'(1)))
        else $error("Sequence start did not restart the base count.");

    a_push_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push |=> (r_seen >= $past(k_eff)))
        else $error("K-mer pushed before enough bases were seen.");

endmodule

/* hw/rtl/rkp_back.sv */
// Back part: pops window jobs, packs the k-mer into four words and holds it in the output register.
// Depends on rkp_pkg; pops jobs from rkp_queue.
module rkp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  rkp_pkg::t_job      i_job,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output rkp_pkg::t_out_item o_out_data
);

    logic                             r_valid;
    rkp_pkg::t_out_item               r_data;
    logic [rkp_pkg::WORD_W-1:0]       words [rkp_pkg::NUM_WORDS];
    rkp_pkg::t_out_item               n_data;
    logic                             take;

    assign take        = !r_valid || !i_out_stall;
    assign o_pop       = i_job_valid && take;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        logic [rkp_pkg::KLEN_W-1:0]   lo;
        logic [rkp_pkg::KLEN_W-1:0]   hi;
        logic [rkp_pkg::KLEN_W-1:0]   sh;
        logic [5:0]                   rem2;
        logic [rkp_pkg::WORD_W-1:0]   mask;
        logic [rkp_pkg::WINDOW_W-1:0] shifted;
        for (int w = 0; w < rkp_pkg::NUM_WORDS; w++) begin
            lo      = rkp_pkg::KLEN_W'(rkp_pkg::BASES_PER_WORD * w);
            hi      = rkp_pkg::KLEN_W'(rkp_pkg::BASES_PER_WORD * (w + 1));
            sh      = (i_job.kmer_len - hi) << 1;
            rem2    = {i_job.kmer_len[4:0], 1'b0};
            mask    = (rkp_pkg::WORD_W'(1) << rem2) - rkp_pkg::WORD_W'(1);
            shifted = i_job.window >> sh;
            if (i_job.kmer_len >= hi) begin
                words[w] = shifted[rkp_pkg::WORD_W-1:0];
            end else if (i_job.kmer_len > lo) begin
                words[w] = i_job.window[rkp_pkg::WORD_W-1:0] & mask;
            end else begin
                words[w] = '0;
            end
        end
        n_data.kmer_word0 = words[0];
        n_data.kmer_word1 = words[1];
        n_data.kmer_word2 = words[2];
        n_data.kmer_word3 = words[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_job_valid) begin
            r_data <= n_data;
        end
    end

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("Popped job did not reach the output register.");

endmodule

/* hw/rtl/rolling_kmer_packer.sv */
// Top level of the rolling k-mer packer: configuration register and the front, queue and back.
// Depends on rkp_pkg, rkp_front, rkp_queue and rkp_back.
//
// Bases arrive on the input channel (i_in_valid, o_in_stall, i_in_data), one per transfer.
// A base with seq_start set clears the window and the count before it is taken in.
// Once k bases of the current sequence are known, every base yields one k-mer on the
// output channel (o_out_valid, i_out_stall, o_out_data); earlier bases yield nothing.
// k is register kmer_length at APB byte address 0, reset to 31; 0 acts as 1, over 128 as 128.
// The front part takes one base per cycle while the queue is not full and shifts the
// 256-bit window; the back part packs the words and registers them. A k-mer is held
// in the queue and then in the output register before it appears on the output.
// Throughput is one base per cycle while the queue is not full, set by the front part's window shift.
// A stalled receiver holds the output register; the two-entry queue then fills and
// o_in_stall rises when it is full. Reset clears the window, the count, the queue
// and the output valid, and sets kmer_length to 31.
module rolling_kmer_packer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rkp_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rkp_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rkp_pkg::PADDR_W-1:0] paddr,
    input  logic [rkp_pkg::PDATA_W-1:0] pwdata,
    output logic [rkp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [rkp_pkg::KLEN_W-1:0]    r_kmer_length;
    logic [rkp_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          queue_full;
    logic                          job_valid;
    logic                          pop;
    rkp_pkg::t_push                push;
    rkp_pkg::t_job                 job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rkp_pkg::PADDR_W-1:2];

    always_comb begin
        if (reg_idx == rkp_pkg::REG_KMER_LENGTH) begin
            prdata = rkp_pkg::PDATA_W'(r_kmer_length);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= rkp_pkg::KMER_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && reg_idx == rkp_pkg::REG_KMER_LENGTH) begin
            r_kmer_length <= pwdata[rkp_pkg::KLEN_W-1:0];
        end
    end

    rkp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_item        (i_in_data),
        .i_queue_full  (queue_full),
        .i_kmer_length (r_kmer_length),
        .o_stall       (o_in_stall),
        .o_push        (push)
    );

    rkp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (job_valid),
        .o_job   (job)
    );

    rkp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for rolling_kmer_packer: drives bases and kmer_length writes,
// predicts each packed k-mer in a scoreboard class and compares every output transfer.
// Depends on rkp_pkg and the rolling_kmer_packer RTL.
`timescale 1ns / 1ps

module tb_top;
    import rkp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    class kmer_scoreboard;
        logic [WINDOW_W-1:0] window;
        logic [SEEN_W-1:0]   bases_seen;
        logic [KLEN_W-1:0]   kmer_length;
        t_out_item           expected_kmers[$];
        int unsigned         failures;

        function new();
            window      = '0;
            bases_seen  = '0;
            kmer_length = KMER_LENGTH_RESET;
            failures    = 0;
        endfunction

        function int unsigned active_length();
            if (kmer_length == 0) begin
                return 1;
            end
            if (kmer_length > MAX_BASES) begin
                return MAX_BASES;
            end
            return kmer_length;
        endfunction

        function bit note_base(t_in_item item);
            logic [7:0]  ch;
            logic [1:0]  code;
            logic [63:0] words [NUM_WORDS];
            t_out_item   kmer;
            int unsigned k, rem, w, pos, sh, age;
            ch = (item.base_char >= "a" && item.base_char <= "z") ?
                 item.base_char - 8'h20 : item.base_char;
            case (ch)
                CHAR_C_UPPER: code = CODE_C;
                CHAR_G_UPPER: code = CODE_G;
                CHAR_T_UPPER: code = CODE_T;
                default:      code = CODE_A;
            endcase
            if (item.seq_start) begin
                window     = '0;
                bases_seen = '0;
            end
            window = {window[WINDOW_W-3:0], code};
            if (bases_seen != '1) begin
                bases_seen++;
            end
            k = active_length();
            if (bases_seen < k) begin
                return 0;
            end
            foreach (words[j]) begin
                words[j] = '0;
            end
            rem = k % BASES_PER_WORD;
            for (int unsigned i = 0; i < k; i++) begin
                w   = i / BASES_PER_WORD;
                pos = i % BASES_PER_WORD;
                if (rem != 0 && w == k / BASES_PER_WORD) begin
                    sh = 2 * (rem - 1 - pos);
                end else begin
                    sh = 2 * (BASES_PER_WORD - 1 - pos);
                end
                age = k - 1 - i;
                words[w] |= 64'(window[2*age +: 2]) << sh;
            end
            kmer.kmer_word0 = words[0];
            kmer.kmer_word1 = words[1];
            kmer.kmer_word2 = words[2];
            kmer.kmer_word3 = words[3];
            expected_kmers.push_back(kmer);
            return 1;
        endfunction

        function void check_kmer(t_out_item got);
            t_out_item want;
            if (expected_kmers.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected k-mer %h %h %h %h", got.kmer_word0,
                             got.kmer_word1, got.kmer_word2, got.kmer_word3);
                end
                return;
            end
            want = expected_kmers.pop_front();
            if (got.kmer_word0 !== want.kmer_word0 || got.kmer_word1 !== want.kmer_word1 ||
                got.kmer_word2 !== want.kmer_word2 || got.kmer_word3 !== want.kmer_word3) begin
                failures++;
                if (failures <= 10) begin
                    $display("k-mer mismatch: expected %h %h %h %h", want.kmer_word0,
                             want.kmer_word1, want.kmer_word2, want.kmer_word3);
                    $display("                actual   %h %h %h %h", got.kmer_word0,
                             got.kmer_word1, got.kmer_word2, got.kmer_word3);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    kmer_scoreboard      sb;
    bit                  idle_on;
    int unsigned         stall_left;
    int unsigned         cycles;
    logic [7:0]          nucleotides [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

    rolling_kmer_packer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("rolling_kmer_packer: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_kmer(o_out_data);
        end
    end

    always @(negedge i_clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
        end
        if (idle_on && stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end
    end

    task automatic send_base(input t_in_item item, output bit hit);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        hit = sb.note_base(item);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_kmers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_kmer_length(input logic [KLEN_W-1:0] len);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_KMER_LENGTH, 2'b00};
        pwdata  <= PDATA_W'(len);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.kmer_length = len;
    endtask

    // Mostly well-formed sequences at least k long; some are cut short, and about one base
    // in ten is an arbitrary byte. With carry_on the first sequence continues the window.
    task automatic run_phase(input bit carry_on, input int unsigned long_len);
        t_in_item    item;
        int unsigned k, items, hits, seq_len;
        bit          first, hit;
        k     = sb.active_length();
        items = 0;
        hits  = 0;
        first = 1'b1;
        while (items < 30 || hits < 4) begin
            if ($urandom_range(0, 4) == 0) begin
                seq_len = $urandom_range(1, k);
            end else begin
                seq_len = k + $urandom_range(0, 24);
            end
            if (first && long_len > seq_len) begin
                seq_len = long_len;
            end
            for (int unsigned j = 0; j < seq_len; j++) begin
                item.seq_start = (j == 0) && !(first && carry_on);
                if ($urandom_range(0, 9) == 0) begin
                    item.base_char = 8'($urandom_range(0, 255));
                end else begin
                    item.base_char = nucleotides[$urandom_range(0, 7)];
                end
                send_base(item, hit);
                items++;
                hits += hit;
            end
            first = 1'b0;
        end
    endtask

    initial begin
        t_in_item    item;
        bit          hit;
        logic [7:0]  directed [22] = '{"A", "C", "G", "T", "a", "c", "g", "t", "N", "n",
                                       8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA, "T", "G",
                                       "G", "c", "x", "A"};
        logic [7:0]  lengths [5] = '{8'd1, 8'd0, 8'd32, 8'd33, 8'd255};
        sb          = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_on     = 1'b1;
        stall_left  = 0;
        cycles      = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length of 31, every character class, and a restart in the middle.
        foreach (directed[j]) begin
            item.base_char = directed[j];
            item.seq_start = (j == 0) || (j == 17);
            send_base(item, hit);
        end
        run_phase(1'b1, 0);

        // The longest length also runs one sequence past the saturating base count.
        foreach (lengths[j]) begin
            drain();
            idle_on = ($urandom_range(0, 3) != 0);
            write_kmer_length(lengths[j]);
            run_phase(1'($urandom_range(0, 1)), (lengths[j] == 8'd255) ? 258 : 0);
        end

        drain();
        idle_on = 1'b0;
        write_kmer_length(8'($urandom_range(1, 40)));
        run_phase(1'b1, 0);

        drain();
        if (sb.failures == 0 && sb.expected_kmers.size() == 0) begin
            $display("rolling_kmer_packer: match");
        end else begin
            $display("rolling_kmer_packer: mismatch");
        end
        $finish;
    end

endmodule
